FILE: hw/rtl/set_assoc_cache_hit_miss_unit_macros.svh
// assertion macros shared by the cache hit/miss rtl
// no dependencies; included by the files that carry assertions
`ifndef SET_ASSOC_CACHE_HIT_MISS_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_HIT_MISS_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SACHM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sachm assertion failed");

// next-cycle implication, checked outside reset
`define SACHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sachm assertion failed");

`endif

FILE: hw/rtl/sachm_pkg.sv
// package for the set-associative cache hit/miss unit
// field widths, defaults, register indexes and the controller state type
package sachm_pkg;

  // default geometry
  localparam int unsigned SetsDef        = 4;
  localparam int unsigned WaysDef        = 2;
  localparam int unsigned AddressBitsDef = 32;
  localparam int unsigned AgeBitsDef     = 16;

  // fixed field widths
  localparam int unsigned OffsetW  = 5;
  localparam int unsigned IndexW   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [OffsetW-1:0] OffsetRst = 5'd4;
  localparam logic [IndexW-1:0]  IndexRst  = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_INDEX_BITS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_LOOKUP,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

FILE: hw/rtl/sachm_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no package dependencies
module sachm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/set_assoc_cache_hit_miss_unit.sv
// Set-associative cache hit/miss unit. One address beat in, one result beat out (hit, way).
// All tag state sits in one ram, one row per set holding valid, tag and age of every way.
// Every access ages every line, so each access sweeps all SETS rows through the ram
// (read, age, write back, pipelined one row a cycle). A lookup state follows; a miss
// then scans the ways for the oldest one and writes the refilled row; the done state
// hands the result to the output register, waiting while that register is full. The
// unit returns to idle before it takes the next address beat, so it takes no new beat
// until the current access is through; this is set by the single ram port pair and
// the age sweep. After reset a clearing pass zeroes every ram row; no address beat is
// taken during it, config writes are.
// The output register lets the next address beat in while a result waits.
// Depends on sachm_pkg, sachm_ram and the assertion macro header.
`include "set_assoc_cache_hit_miss_unit_macros.svh"

module set_assoc_cache_hit_miss_unit #(
  parameter int unsigned SETS     = sachm_pkg::SetsDef,
  parameter int unsigned WAYS     = sachm_pkg::WaysDef,
  parameter int unsigned ADDR_W   = sachm_pkg::AddressBitsDef,
  parameter int unsigned AGE_BITS = sachm_pkg::AgeBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // address channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ADDR_W-1:0]                 address_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic                              way_o,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sachm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sachm_pkg::CfgDataW-1:0]    cfg_data_i
);

  // geometry
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned CNT_W   = $clog2(SETS + 1);
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IDX_MAX = $clog2(SETS + 1) - 1;  // floor(log2(SETS))
  // one line: {valid, tag, age}
  localparam int unsigned LINE_W  = 1 + ADDR_W + AGE_BITS;
  localparam int unsigned ROW_W   = WAYS * LINE_W;

  sachm_pkg::state_e state_q, state_d;

  // config registers
  logic [sachm_pkg::OffsetW-1:0] offset_bits_q;
  logic [sachm_pkg::IndexW-1:0]  index_bits_q;

  // sweep / clear control
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             pend_valid_q, pend_valid_d;
  logic [SET_W-1:0] pend_addr_q, pend_addr_d;

  // access payload
  logic [SET_W-1:0]    set_q, set_d;
  logic [ADDR_W-1:0]   tag_q, tag_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [WAY_W-1:0]    scan_q, scan_d;
  logic [AGE_BITS-1:0] best_q, best_d;
  logic [WAY_W-1:0]    chosen_q, chosen_d;
  logic                res_hit_q, res_hit_d;
  logic                res_way_q, res_way_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic hit_q, hit_d;
  logic way_q, way_d;

  // ram port
  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  sachm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshakes
  assign in_ready_o  = (state_q == sachm_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = way_q;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // address split: offset, clamped index, tag above the index
  logic [sachm_pkg::IndexW-1:0] ib;
  logic [ADDR_W-1:0]            shifted;
  logic [ADDR_W-1:0]            idx_mask;

  always_comb begin
    ib = (int'(index_bits_q) > IDX_MAX) ? sachm_pkg::IndexW'(IDX_MAX) : index_bits_q;
    shifted = (int'(offset_bits_q) >= ADDR_W) ? '0 : (address_i >> offset_bits_q);
    idx_mask = ~({ADDR_W{1'b1}} << ib);
    set_d = SET_W'(shifted & idx_mask);
    tag_d = shifted >> ib;
  end

  // age every line of the row coming out of the ram, saturating
  logic [ROW_W-1:0] aged_row;

  always_comb begin
    logic [LINE_W-1:0]   line;
    logic [AGE_BITS-1:0] age;
    aged_row = '0;
    for (int unsigned w = 0; w < WAYS; w++) begin
      line = ram_rdata[w*LINE_W +: LINE_W];
      age  = line[AGE_BITS-1:0];
      if (age != {AGE_BITS{1'b1}}) begin
        age = age + 1'b1;
      end
      aged_row[w*LINE_W +: LINE_W] = {line[LINE_W-1:AGE_BITS], age};
    end
  end

  // tag compare on the captured row, lowest matching way wins
  logic             any_hit;
  logic [WAY_W-1:0] hit_way;

  always_comb begin
    logic [LINE_W-1:0] line;
    any_hit = 1'b0;
    hit_way = '0;
    for (int w = int'(WAYS) - 1; w >= 0; w--) begin
      line = row_q[w*LINE_W +: LINE_W];
      if (line[LINE_W-1] && (line[AGE_BITS +: ADDR_W] == tag_q)) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // age of the way under scan
  logic [AGE_BITS-1:0] scan_age;
  assign scan_age = row_q[int'(scan_q)*LINE_W +: AGE_BITS];

  // row with the victim way refilled
  logic [ROW_W-1:0] fill_row;

  always_comb begin
    fill_row = row_q;
    for (int unsigned w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == chosen_q) begin
        fill_row[w*LINE_W +: LINE_W] = {1'b1, tag_q, {AGE_BITS{1'b0}}};
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sachm_pkg::ST_CLEAR: begin
        if (rd_cnt_q == CNT_W'(SETS - 1)) begin
          state_d = sachm_pkg::ST_IDLE;
        end
      end
      sachm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = sachm_pkg::ST_SWEEP;
        end
      end
      sachm_pkg::ST_SWEEP: begin
        // last row is written back in the cycle the read counter is done
        if (rd_cnt_q == CNT_W'(SETS)) begin
          state_d = sachm_pkg::ST_LOOKUP;
        end
      end
      sachm_pkg::ST_LOOKUP: begin
        state_d = any_hit ? sachm_pkg::ST_DONE : sachm_pkg::ST_SCAN;
      end
      sachm_pkg::ST_SCAN: begin
        if (scan_q == WAY_W'(WAYS - 1)) begin
          state_d = sachm_pkg::ST_FILL;
        end
      end
      sachm_pkg::ST_FILL: begin
        state_d = sachm_pkg::ST_DONE;
      end
      sachm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sachm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sachm_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_raddr    = rd_cnt_q[SET_W-1:0];
    ram_wdata    = aged_row;
    rd_cnt_d     = rd_cnt_q;
    pend_valid_d = 1'b0;
    pend_addr_d  = pend_addr_q;
    row_d        = row_q;
    scan_d       = scan_q;
    best_d       = best_q;
    chosen_d     = chosen_q;
    res_hit_d    = res_hit_q;
    res_way_d    = res_way_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    hit_d        = hit_q;
    way_d        = way_q;

    unique case (state_q)
      sachm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_cnt_q[SET_W-1:0];
        ram_wdata = '0;
        rd_cnt_d  = (rd_cnt_q == CNT_W'(SETS - 1)) ? '0 : rd_cnt_q + 1'b1;
      end
      sachm_pkg::ST_IDLE: begin
        rd_cnt_d = '0;
      end
      sachm_pkg::ST_SWEEP: begin
        if (rd_cnt_q != CNT_W'(SETS)) begin
          ram_re       = 1'b1;
          rd_cnt_d     = rd_cnt_q + 1'b1;
          pend_valid_d = 1'b1;
          pend_addr_d  = rd_cnt_q[SET_W-1:0];
        end else begin
          rd_cnt_d = '0;
        end
        if (pend_valid_q) begin
          ram_we = 1'b1;
          if (pend_addr_q == set_q) begin
            row_d = aged_row;
          end
        end
      end
      sachm_pkg::ST_LOOKUP: begin
        res_hit_d = any_hit;
        res_way_d = hit_way[0];
        scan_d    = '0;
        best_d    = '0;
        chosen_d  = '0;
      end
      sachm_pkg::ST_SCAN: begin
        // first strictly greater age wins, way 0 when all are zero
        if (scan_age > best_q) begin
          best_d   = scan_age;
          chosen_d = scan_q;
        end
        if (scan_q != WAY_W'(WAYS - 1)) begin
          scan_d = scan_q + 1'b1;
        end
      end
      sachm_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = set_q;
        ram_wdata = fill_row;
        res_hit_d = 1'b0;
        res_way_d = chosen_q[0];
      end
      sachm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = res_hit_q;
          way_d       = res_way_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sachm_pkg::ST_CLEAR;
      rd_cnt_q      <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      offset_bits_q <= sachm_pkg::OffsetRst;
      index_bits_q  <= sachm_pkg::IndexRst;
    end else begin
      state_q      <= state_d;
      rd_cnt_q     <= rd_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (sachm_pkg::cfg_reg_e'(cfg_index_i))
          sachm_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[sachm_pkg::OffsetW-1:0];
          sachm_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i[sachm_pkg::IndexW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
    pend_addr_q <= pend_addr_d;
    row_q       <= row_d;
    scan_q      <= scan_d;
    best_q      <= best_d;
    chosen_q    <= chosen_d;
    res_hit_q   <= res_hit_d;
    res_way_q   <= res_way_d;
    hit_q       <= hit_d;
    way_q       <= way_d;
  end

  // the sweep never writes the row it reads in the same cycle
  `SACHM_ASSERT_NOW(a_sweep_no_overlap, clk_i, rst_ni,
    state_q == sachm_pkg::ST_SWEEP && ram_we && ram_re, ram_waddr != ram_raddr)
  // an accepted beat starts a sweep from row zero
  `SACHM_ASSERT_NEXT(a_accept_starts_sweep, clk_i, rst_ni,
    in_fire, state_q == sachm_pkg::ST_SWEEP && rd_cnt_q == '0 && !pend_valid_q)
  // the refill goes to the accessed set
  `SACHM_ASSERT_NOW(a_fill_target, clk_i, rst_ni,
    state_q == sachm_pkg::ST_FILL, ram_we && ram_waddr == set_q)
  // a result appears only out of the done state
  `SACHM_ASSERT_NEXT(a_result_from_done, clk_i, rst_ni,
    !out_valid_q && state_q != sachm_pkg::ST_DONE, !out_valid_q)

endmodule

FILE: tb/sv/set_assoc_cache_hit_miss_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for the set-associative cache hit/miss unit: address beats in,
// hit/way beats out, checked against an in-bench tag/age tracker held in a scoreboard class
// depends on sachm_pkg and the set_assoc_cache_hit_miss_unit rtl
module set_assoc_cache_hit_miss_unit_test;

  // geometry of the instance under test (rtl defaults)
  localparam int unsigned Sets         = sachm_pkg::SetsDef;
  localparam int unsigned Ways         = sachm_pkg::WaysDef;
  localparam int unsigned AddrBits     = sachm_pkg::AddressBitsDef;
  localparam int unsigned AgeBits      = sachm_pkg::AgeBitsDef;
  localparam int unsigned Lines        = Sets * Ways;
  // index width in use is clamped to floor(log2(Sets))
  localparam int unsigned MaxIndexBits = $clog2(Sets + 1) - 1;
  // watchdog limit, this leaves plenty of room over the slowest run
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseBeats   = 250;
  localparam int unsigned AgingHits    = 250;
  localparam int unsigned StallCycles  = 300;

  typedef struct packed {
    logic hit;
    logic way;
  } lookup_t;

  // tracks valid/tag/age of every line and the results still owed by the unit
  class lookup_scoreboard;
    logic [sachm_pkg::OffsetW-1:0] offset_bits;
    logic [sachm_pkg::IndexW-1:0]  index_bits;
    logic                          line_valid[Lines];
    logic [AddrBits-1:0]           line_tag[Lines];
    logic [AgeBits-1:0]            line_age[Lines];
    lookup_t                       owed_q[$];
    int unsigned                   mismatches;

    function new();
      offset_bits = sachm_pkg::OffsetRst;
      index_bits  = sachm_pkg::IndexRst;
      mismatches  = 0;
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_age[i]   = '0;
      end
    endfunction

    function void write_reg(sachm_pkg::cfg_reg_e idx, logic [sachm_pkg::CfgDataW-1:0] data);
      case (idx)
        sachm_pkg::CFG_OFFSET_BITS: offset_bits = data;
        sachm_pkg::CFG_INDEX_BITS:  index_bits  = data[sachm_pkg::IndexW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // accepted address beat: age all lines, look up the set, refill on a miss
    function void note_address(logic [AddrBits-1:0] addr);
      logic [AddrBits-1:0] shifted;
      logic [AddrBits-1:0] tag_v;
      logic [AgeBits-1:0]  oldest;
      int unsigned         ib;
      int unsigned         set_v;
      int unsigned         chosen;
      int unsigned         k;
      int unsigned         i;
      lookup_t             res;
      ib      = (index_bits > MaxIndexBits) ? MaxIndexBits : index_bits;
      shifted = addr >> offset_bits;
      set_v   = (shifted & ((32'd1 << ib) - 1)) % Sets;
      tag_v   = shifted >> ib;
      for (i = 0; i < Lines; i++)
        if (line_age[i] != '1) line_age[i]++;
      res = '0;
      for (i = 0; i < Ways; i++) begin
        k = set_v * Ways + i;
        if (!res.hit && line_valid[k] && line_tag[k] == tag_v) begin
          res.hit = 1'b1;
          res.way = i[0];
        end
      end
      if (!res.hit) begin
        // oldest way since fill, first one on a tie
        oldest = '0;
        chosen = 0;
        for (i = 0; i < Ways; i++) begin
          k = set_v * Ways + i;
          if (line_age[k] > oldest) begin
            oldest = line_age[k];
            chosen = i;
          end
        end
        k = set_v * Ways + chosen;
        line_tag[k]   = tag_v;
        line_valid[k] = 1'b1;
        line_age[k]   = '0;
        res.way       = chosen[0];
      end
      owed_q.push_back(res);
    endfunction

    function void check_lookup(logic hit, logic way);
      lookup_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result beat with nothing owed: hit=%0b way=%0b", $time, hit, way);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, hit);
        mismatches++;
      end
      if (way !== want.way) begin
        $display("%0t: way mismatch: expected %0b, got %0b", $time, want.way, way);
        mismatches++;
      end
    endfunction
  endclass

  // dut connections, all inputs known from time zero
  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic [AddrBits-1:0]             address_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            hit_o;
  logic                            way_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [sachm_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [sachm_pkg::CfgDataW-1:0]  cfg_data_i  = '0;

  lookup_scoreboard tracker = new();
  bit               gaps_on = 1'b1;     // random idling on both sides
  int unsigned      results_seen = 0;
  int unsigned      stall_left = 0;
  int unsigned      cycle_count = 0;

  set_assoc_cache_hit_miss_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .address_i   (address_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .way_o       (way_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** set_assoc_cache_hit_miss_unit: FAILED **");
      $finish;
    end
  end

  // result side: check every accepted beat, then pick ready for the next edge;
  // twice in the run ready is held low long enough that the unit backs up
  // into the address channel while the sender keeps offering beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_lookup(hit_o, way_o);
      results_seen++;
      if (results_seen == 400 || results_seen == 1300) stall_left = StallCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !gaps_on || ($urandom_range(99) >= 17);
    end
  end

  // one address beat; valid stays up afterwards so back-to-back beats need no dip
  task automatic send_address(input logic [AddrBits-1:0] addr);
    if (gaps_on) begin
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_address(addr);
  endtask

  // drop valid and wait until every owed result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // write both registers back to back; unused index data bits carry noise
  task automatic configure(input logic [sachm_pkg::OffsetW-1:0] ob,
                           input logic [sachm_pkg::IndexW-1:0] ib);
    logic [sachm_pkg::CfgDataW-1:0] data;
    sachm_pkg::cfg_reg_e            idx;
    int unsigned                    n;
    for (n = 0; n < 2; n++) begin
      idx  = (n == 0) ? sachm_pkg::CFG_OFFSET_BITS : sachm_pkg::CFG_INDEX_BITS;
      data = (n == 0) ? sachm_pkg::CfgDataW'(ob)
                      : {3'($urandom), ib};
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tracker.write_reg(idx, data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a small tag pool over the sets so lines hit, age and get evicted;
  // the rest are all-ones tags, random tags and fully random addresses
  function automatic logic [AddrBits-1:0] pick_address(int unsigned ob, int unsigned ib);
    logic [63:0] tag_v;
    logic [63:0] addr;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return AddrBits'($urandom);
    if (r < 85)      tag_v = $urandom_range(3);
    else if (r < 92) tag_v = 64'hFFFF_FFFF;
    else             tag_v = $urandom;
    addr = (tag_v << (ob + ib)) | (64'($urandom_range(3)) << ob)
         | (64'($urandom) & ((64'd1 << ob) - 1));
    return addr[AddrBits-1:0];
  endfunction

  initial begin : stimulus
    logic [AddrBits-1:0]           addr;
    logic [sachm_pkg::OffsetW-1:0] ob;
    logic [sachm_pkg::IndexW-1:0]  ib;
    int unsigned                   p;
    int unsigned                   n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: offset 4, index 2 -> tag starts at bit 6
    send_address(32'h0000_0000);   // cold miss, all ages equal -> way 0
    send_address(32'h0000_000F);   // same line, other offset -> hit
    send_address(32'hFFFF_FFFF);   // top set, all-ones tag
    send_address(32'hFFFF_FFF0);
    send_address(32'h0000_0040);   // set 0 fills its second way
    send_address(32'h0000_0080);   // third tag in set 0 evicts the older fill
    send_address(32'h0000_0000);
    send_address(32'h0000_0040);
    drain();

    // offset of 31, index 3 clamped to 2: only the top bit reaches the index
    configure(5'd31, 2'd3);
    send_address(32'h8000_0000);
    send_address(32'h0000_0000);
    send_address(32'h7FFF_FFFF);
    send_address(32'hFFFF_FFFF);
    drain();

    // no offset, no index: whole address is the tag, everything in set 0
    configure(5'd0, 2'd0);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0001);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
    drain();

    configure(5'd16, 2'd1);
    send_address(32'h0001_0000);
    send_address(32'h0002_0000);
    send_address(32'h0001_FFFF);
    send_address(32'hFFFF_0000);
    drain();

    // random phases, extremes of both registers first
    for (p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       begin ob = 5'd0;  ib = 2'd0; end
        1:       begin ob = 5'd31; ib = 2'd3; end
        2:       begin ob = 5'd4;  ib = 2'd2; end
        3:       begin ob = 5'd16; ib = 2'd1; end
        default: begin ob = 5'($urandom); ib = 2'($urandom); end
      endcase
      configure(ob, ib);
      for (n = 0; n < PhaseBeats; n++) send_address(pick_address(ob, ib));
      drain();
    end

    // both sides running flat out: fill both ways of set 0, keep hitting
    // them so their ages climb, then miss in every set
    gaps_on = 1'b0;
    configure(5'd4, 2'd2);
    send_address(32'h1000 << 6);
    send_address(32'h1001 << 6);
    for (n = 0; n < AgingHits; n++) begin
      addr = (32'h1000 + n[0]) << 6;
      send_address(addr | $urandom_range(15));
    end
    for (n = 0; n < Sets; n++) send_address((32'h1002 << 6) | (n << 4));
    drain();

    // let any stray result show up before the verdict
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("** set_assoc_cache_hit_miss_unit: PASSED **");
    end else begin
      $display("** set_assoc_cache_hit_miss_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: set_assoc_cache_hit_miss_unit.f
+incdir+hw/rtl
hw/rtl/sachm_pkg.sv
hw/rtl/sachm_ram.sv
hw/rtl/set_assoc_cache_hit_miss_unit.sv
tb/sv/set_assoc_cache_hit_miss_unit_test.sv
